FILE: rtl/core/erm_pkg.sv
// event rate monitor package: widths, register and opcode codes, control structs
// no dependencies; imported by every other file of the block
package erm_pkg;

    localparam int TIME_WIDTH     = 48;
    localparam int COUNT_WIDTH    = 32;
    localparam int TPS_WIDTH      = 32;
    localparam int RATE_WIDTH     = 32;
    localparam int FRAC_BITS      = 8;
    localparam int NUM_WIDTH      = COUNT_WIDTH + TPS_WIDTH;
    localparam int DIVD_WIDTH     = NUM_WIDTH + FRAC_BITS;
    localparam int STEP_WIDTH     = $clog2(DIVD_WIDTH);
    localparam int CFG_DATA_WIDTH = 64;
    localparam int CFG_ADDR_WIDTH = 4;

    localparam logic [TIME_WIDTH-1:0]  WINDOW_RESET = TIME_WIDTH'(2000000);
    localparam logic [TPS_WIDTH-1:0]   TPS_RESET    = TPS_WIDTH'(1000000);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = '1;

    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_TPS    = 1'b1;

    localparam logic OPC_EVENT   = 1'b0;
    localparam logic OPC_ANALYSE = 1'b1;

    typedef logic [TIME_WIDTH-1:0]  time_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [TPS_WIDTH-1:0]   tps_t;
    typedef logic [RATE_WIDTH-1:0]  rate_t;

    typedef struct packed {
        logic accept_event;
        logic accept_analyse;
        logic mul_load;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } dp_status_t;

endpackage

FILE: rtl/core/erm_in_if.sv
// input channel of the event rate monitor: valid, ready, opcode and timestamp
// depends on erm_pkg
interface erm_in_if;
    import erm_pkg::*;

    logic  valid;
    logic  ready;
    logic  opcode;
    time_t now_time;

    modport source (output valid, output opcode, output now_time, input ready);
    modport sink   (input valid, input opcode, input now_time, output ready);
endinterface

FILE: rtl/core/erm_out_if.sv
// result channel of the event rate monitor: valid, ready and held diagnostics
// depends on erm_pkg
interface erm_out_if;
    import erm_pkg::*;

    logic  valid;
    logic  ready;
    logic  connected;
    time_t min_interval;
    time_t max_interval;
    rate_t rate_q8;
    logic  window_closed;

    modport source (output valid, output connected, output min_interval,
                    output max_interval, output rate_q8, output window_closed,
                    input ready);
    modport sink   (input valid, input connected, input min_interval,
                    input max_interval, input rate_q8, input window_closed,
                    output ready);
endinterface

FILE: rtl/core/erm_cfg.sv
// configuration registers of the event rate monitor behind an apb-style port
// depends on erm_pkg
module erm_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [erm_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
    input  logic [erm_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
    output logic [erm_pkg::CFG_DATA_WIDTH-1:0]  prdata,
    output logic                                pready,
    output erm_pkg::time_t                      window_ticks,
    output erm_pkg::tps_t                       ticks_per_second
);
    import erm_pkg::*;

    time_t window_reg;
    tps_t  tps_reg;
    logic  reg_index;
    logic  wr_en;

    assign reg_index = paddr[CFG_ADDR_WIDTH-1];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            tps_reg    <= TPS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_WINDOW: window_reg <= pwdata[TIME_WIDTH-1:0];
                REG_TPS:    tps_reg    <= pwdata[TPS_WIDTH-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_WINDOW: prdata = CFG_DATA_WIDTH'(window_reg);
            REG_TPS:    prdata = CFG_DATA_WIDTH'(tps_reg);
            default:    prdata = '0;
        endcase
    end

    assign window_ticks     = window_reg;
    assign ticks_per_second = tps_reg;

endmodule

FILE: rtl/core/erm_dp.sv
// datapath of the event rate monitor: window statistics, held diagnostics,
// rate multiplier, restoring divider and result register; depends on erm_pkg
module erm_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  erm_pkg::ctrl_cmd_t  cmd,
    output erm_pkg::dp_status_t status,
    input  erm_pkg::time_t      now_time,
    input  erm_pkg::time_t      window_ticks,
    input  erm_pkg::tps_t       ticks_per_second,
    output logic                connected,
    output erm_pkg::time_t      min_interval,
    output erm_pkg::time_t      max_interval,
    output erm_pkg::rate_t      rate_q8,
    output logic                window_closed
);
    import erm_pkg::*;

    // window statistics and held diagnostics
    time_t  last_event_reg;
    time_t  last_window_reg;
    count_t count_reg;
    time_t  run_min_reg;
    time_t  run_max_reg;
    logic   held_conn_reg;
    time_t  held_min_reg;
    time_t  held_max_reg;
    rate_t  held_rate_reg;

    // divider
    time_t                 elapsed_reg;
    count_t                count_snap_reg;
    logic [DIVD_WIDTH-1:0] dividend_reg;
    time_t                 rem_reg;
    rate_t                 quot_reg;
    logic                  ovf_reg;
    logic [STEP_WIDTH-1:0] step_reg;
    logic                  closed_reg;

    // result register
    logic  out_conn_reg;
    time_t out_min_reg;
    time_t out_max_reg;
    rate_t out_rate_reg;
    logic  out_closed_reg;

    time_t                 delta;
    time_t                 elapsed;
    logic                  closed;
    logic                  count_nz;
    logic [NUM_WIDTH-1:0]  product;
    logic [TIME_WIDTH:0]   rem_shift;
    logic [TIME_WIDTH:0]   rem_sub;
    logic                  rem_ge;
    time_t                 rem_next;
    rate_t                 quot_next;
    logic                  ovf_next;

    assign delta    = now_time - last_event_reg;
    assign elapsed  = now_time - last_window_reg;
    assign closed   = elapsed > window_ticks;
    assign count_nz = count_reg != '0;

    assign product  = NUM_WIDTH'(count_snap_reg) * NUM_WIDTH'(ticks_per_second);

    assign rem_shift = {rem_reg, dividend_reg[DIVD_WIDTH-1]};
    assign rem_sub   = rem_shift - {1'b0, elapsed_reg};
    assign rem_ge    = rem_shift >= {1'b0, elapsed_reg};
    assign rem_next  = rem_ge ? rem_sub[TIME_WIDTH-1:0] : rem_shift[TIME_WIDTH-1:0];
    assign quot_next = {quot_reg[RATE_WIDTH-2:0], rem_ge};
    assign ovf_next  = ovf_reg | quot_reg[RATE_WIDTH-1];

    assign status.need_div = closed && count_nz;
    assign status.div_last = step_reg == STEP_WIDTH'(DIVD_WIDTH - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_event_reg  <= '0;
            last_window_reg <= '0;
            count_reg       <= '0;
            run_min_reg     <= '1;
            run_max_reg     <= '0;
            held_conn_reg   <= 1'b0;
            held_min_reg    <= '0;
            held_max_reg    <= '0;
            held_rate_reg   <= '0;
            step_reg        <= '0;
        end
        else
        begin
            if (cmd.accept_event)
            begin
                held_conn_reg  <= 1'b1;
                last_event_reg <= now_time;
                if (count_reg != COUNT_MAX)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (delta < run_min_reg)
                begin
                    run_min_reg <= delta;
                end
                if (delta > run_max_reg)
                begin
                    run_max_reg <= delta;
                end
            end
            if (cmd.accept_analyse && closed)
            begin
                last_window_reg <= now_time;
                if (!count_nz)
                begin
                    held_conn_reg <= 1'b0;
                    held_min_reg  <= '0;
                    held_max_reg  <= '0;
                    held_rate_reg <= '0;
                end
                else
                begin
                    held_conn_reg <= 1'b1;
                    held_min_reg  <= run_min_reg;
                    held_max_reg  <= run_max_reg;
                    count_reg     <= '0;
                    run_min_reg   <= '1;
                    run_max_reg   <= '0;
                end
            end
            if (cmd.mul_load)
            begin
                step_reg <= '0;
            end
            if (cmd.div_step)
            begin
                step_reg <= step_reg + 1'b1;
                if (status.div_last)
                begin
                    held_rate_reg <= ovf_next ? '1 : quot_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_analyse)
        begin
            closed_reg     <= closed;
            elapsed_reg    <= elapsed;
            count_snap_reg <= count_reg;
        end
        if (cmd.mul_load)
        begin
            dividend_reg <= {product, {FRAC_BITS{1'b0}}};
            rem_reg      <= '0;
            quot_reg     <= '0;
            ovf_reg      <= 1'b0;
        end
        if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[DIVD_WIDTH-2:0], 1'b0};
            rem_reg      <= rem_next;
            quot_reg     <= quot_next;
            ovf_reg      <= ovf_next;
        end
        if (cmd.out_load)
        begin
            out_conn_reg   <= held_conn_reg;
            out_min_reg    <= held_min_reg;
            out_max_reg    <= held_max_reg;
            out_rate_reg   <= held_rate_reg;
            out_closed_reg <= closed_reg;
        end
    end

    assign connected      = out_conn_reg;
    assign min_interval   = out_min_reg;
    assign max_interval   = out_max_reg;
    assign rate_q8        = out_rate_reg;
    assign window_closed  = out_closed_reg;

endmodule

FILE: rtl/core/erm_ctrl.sv
// controller of the event rate monitor: item acceptance, divider sequencing
// and result handshake; depends on erm_pkg
module erm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_opcode,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  erm_pkg::dp_status_t status,
    output erm_pkg::ctrl_cmd_t  cmd
);
    import erm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_ready = state_reg == ST_IDLE;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.accept_event   = accept && (in_opcode == OPC_EVENT);
        cmd.accept_analyse = accept && (in_opcode == OPC_ANALYSE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept_analyse)
                begin
                    state_next = status.need_div ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/event_rate_monitor.sv
// top level of the event rate monitor: configuration port, controller and datapath
// depends on erm_pkg, erm_in_if, erm_out_if, erm_cfg, erm_ctrl, erm_dp
//
// An event item gives no result; events are taken every cycle while the controller
// is idle, also while a result waits on the output. An analyse item gives one result:
// when no window closes or the window closed empty, the controller goes from idle
// straight to its done state; when a window closes with events in it, it passes a
// multiply state, 72 steps of the restoring divider that forms the Q24.8 rate, and
// the done state that loads the result register; the input is not ready during that
// time, and the done state stretches for as long as the previous result still waits
// on the output. Configuration is window_ticks (48 bits) at byte address 0 and
// ticks_per_second (32 bits) at byte address 8, written with no wait states.
module event_rate_monitor (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [erm_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [erm_pkg::CFG_DATA_WIDTH-1:0] pwdata,
    output logic [erm_pkg::CFG_DATA_WIDTH-1:0] prdata,
    output logic                               pready,
    erm_in_if.sink                             in_ch,
    erm_out_if.source                          out_ch
);
    import erm_pkg::*;

    time_t      window_ticks;
    tps_t       ticks_per_second;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    erm_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .window_ticks     (window_ticks),
        .ticks_per_second (ticks_per_second)
    );

    erm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    erm_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .now_time         (in_ch.now_time),
        .window_ticks     (window_ticks),
        .ticks_per_second (ticks_per_second),
        .connected        (out_ch.connected),
        .min_interval     (out_ch.min_interval),
        .max_interval     (out_ch.max_interval),
        .rate_q8          (out_ch.rate_q8),
        .window_closed    (out_ch.window_closed)
    );

    // an analyse item always leaves the input not ready in the cycle after it is taken
    a_analyse_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && (in_ch.opcode == OPC_ANALYSE) |=> !in_ch.ready)
        else $error("input ready right after an analyse item");

    // a nonzero rate only comes with a connection
    a_rate_conn: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.rate_q8 != '0) |-> out_ch.connected)
        else $error("rate reported without connection");

    // a freshly closed window with events has min not above max
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.window_closed && out_ch.connected
        |-> out_ch.min_interval <= out_ch.max_interval)
        else $error("latched min interval above max interval");

endmodule

FILE: tb/sv/testbench.sv
// testbench for event_rate_monitor: directed window and register cases, back-pressure
// and random event/analyse traffic, all checked against a built-in predictor
// depends on erm_pkg, erm_in_if, erm_out_if and the event_rate_monitor rtl
module testbench;
    import erm_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_HOLD    = 400;

    typedef enum int {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_MOSTLY} sink_mode_t;

    typedef struct packed {
        logic  conn;
        time_t min_iv;
        time_t max_iv;
        rate_t rate;
        logic  closed;
    } diag_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_WIDTH-1:0] paddr;
    logic [CFG_DATA_WIDTH-1:0] pwdata;
    logic [CFG_DATA_WIDTH-1:0] prdata;
    logic pready;

    erm_in_if  in_ch ();
    erm_out_if out_ch ();

    event_rate_monitor dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #5 clk = ~clk;

    // predictor state
    time_t  cfg_window     = WINDOW_RESET;
    tps_t   cfg_tps        = TPS_RESET;
    time_t  prev_event_t   = '0;
    time_t  window_start_t = '0;
    count_t evt_count      = '0;
    time_t  run_min        = '1;
    time_t  run_max        = '0;
    logic   hold_conn      = 1'b0;
    time_t  hold_min       = '0;
    time_t  hold_max       = '0;
    rate_t  hold_rate      = '0;

    diag_t expected_diag_q[$];

    time_t clock_now       = '0;
    int    burst_left      = 0;
    int    long_hold       = 0;
    int    errors          = 0;
    int    items_sent      = 0;
    int    results_checked = 0;
    int    busy_windows    = 0;
    int    settings_used   = 1;

    function automatic time_t rand48();
        return time_t'({$urandom, $urandom});
    endfunction

    // floor(num * 256 / den), saturating at all ones
    function automatic rate_t q8_rate(input logic [63:0] num, input time_t den);
        logic [63:0] quot;
        logic [64:0] rem;
        logic [7:0]  frac;
        quot = num / 64'(den);
        rem  = 65'(num % 64'(den));
        if (quot >= 64'd1 << 24)
            return '1;
        frac = '0;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= 65'(den))
            begin
                rem     = rem - 65'(den);
                frac[0] = 1'b1;
            end
        end
        return {quot[23:0], frac};
    endfunction

    task automatic advance_monitor_model(input logic opc, input time_t t);
        time_t delta;
        time_t elapsed;
        logic  closed;
        if (opc == OPC_EVENT)
        begin
            delta     = t - prev_event_t;
            hold_conn = 1'b1;
            if (evt_count != COUNT_MAX)
                evt_count++;
            if (delta < run_min)
                run_min = delta;
            if (delta > run_max)
                run_max = delta;
            prev_event_t = t;
        end
        else
        begin
            elapsed = t - window_start_t;
            closed  = 1'b0;
            if (elapsed > cfg_window)
            begin
                closed         = 1'b1;
                window_start_t = t;
                if (evt_count == '0)
                begin
                    hold_conn = 1'b0;
                    hold_min  = '0;
                    hold_max  = '0;
                    hold_rate = '0;
                end
                else
                begin
                    hold_conn = 1'b1;
                    hold_min  = run_min;
                    hold_max  = run_max;
                    hold_rate = q8_rate(64'(evt_count) * 64'(cfg_tps), elapsed);
                    evt_count = '0;
                    run_min   = '1;
                    run_max   = '0;
                    busy_windows++;
                end
            end
            expected_diag_q.push_back('{hold_conn, hold_min, hold_max, hold_rate, closed});
        end
    endtask

    task automatic send_item(input logic opc, input time_t t);
        logic seen;
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_ch.valid    <= 1'b1;
        in_ch.opcode   <= opc;
        in_ch.now_time <= t;
        do
        begin
            @(negedge clk);
            seen = in_ch.ready;
            @(posedge clk);
        end
        while (!seen);
        advance_monitor_model(opc, t);
        items_sent++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_diag_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [CFG_DATA_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WINDOW)
            cfg_window = value[TIME_WIDTH-1:0];
        else
            cfg_tps = value[TPS_WIDTH-1:0];
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic test_window_edges();
        send_item(OPC_ANALYSE, 48'd0);
        send_item(OPC_ANALYSE, 48'd2000000);
        send_item(OPC_ANALYSE, 48'd2000001);
        send_item(OPC_EVENT,   48'd2000001);
        send_item(OPC_EVENT,   48'd2000001);
        send_item(OPC_EVENT,   48'd2000500);
        send_item(OPC_ANALYSE, 48'd4000002);
        send_item(OPC_ANALYSE, 48'd4000003);
        send_item(OPC_EVENT,   48'hFFFF_FFFF_FFFF);
        send_item(OPC_ANALYSE, 48'hFFFF_FFFF_FFFF);
        // timestamps wrap back to small values
        send_item(OPC_EVENT,   48'd5);
        send_item(OPC_ANALYSE, 48'd10);
        send_item(OPC_ANALYSE, 48'd3000000);
        send_item(OPC_ANALYSE, 48'd6000000);
        clock_now = 48'd6000000;
    endtask

    task automatic test_special_registers();
        settle();
        cfg_write(REG_TPS, '0);
        settings_used++;
        send_item(OPC_EVENT,   clock_now + 48'd1);
        send_item(OPC_EVENT,   clock_now + 48'd2);
        send_item(OPC_ANALYSE, clock_now + 48'd3000000);
        clock_now = clock_now + 48'd3000000;
        settle();
        cfg_write(REG_TPS, 64'hFFFF_FFFF);
        cfg_write(REG_WINDOW, '0);
        settings_used++;
        send_item(OPC_ANALYSE, clock_now);
        for (int k = 1; k <= 4; k++)
            send_item(OPC_EVENT, clock_now + 48'(k));
        send_item(OPC_ANALYSE, clock_now + 48'd5);
        send_item(OPC_ANALYSE, clock_now + 48'd5);
        clock_now = clock_now + 48'd5;
    endtask

    task automatic test_output_hold_off();
        long_hold = LONG_HOLD;
        for (int k = 0; k < 40; k++)
        begin
            clock_now = clock_now + 48'($urandom_range(0, 3));
            send_item(($urandom_range(0, 1) == 0) ? OPC_EVENT : OPC_ANALYSE, clock_now);
        end
    endtask

    task automatic run_phase(input time_t win, input tps_t tps, input time_t max_step,
                             input int count);
        logic [63:0] step;
        logic        opc;
        settle();
        cfg_write(REG_WINDOW, {16'($urandom), win});
        cfg_write(REG_TPS, {$urandom, tps});
        settings_used++;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 19))
                0:       clock_now = rand48();
                1, 2:    clock_now = clock_now;
                default:
                begin
                    step      = {$urandom, $urandom} % (64'(max_step) + 64'd1);
                    clock_now = clock_now + time_t'(step);
                end
            endcase
            opc = ($urandom_range(0, 4) == 0) ? OPC_ANALYSE : OPC_EVENT;
            send_item(opc, clock_now);
        end
    endtask

    task automatic test_random_traffic();
        run_phase(48'd1, 32'd1, 48'd3, 220);
        run_phase(WINDOW_RESET, TPS_RESET, 48'd200000, 220);
        run_phase(48'($urandom_range(1, 5000)), $urandom, 48'd600, 220);
        run_phase(48'hFFFF_FFFF_FFFF, $urandom, 48'h100_0000_0000, 150);
        run_phase(rand48() | 48'h4000_0000_0000, 32'hFFFF_FFFF, 48'h1000_0000_0000, 220);
        run_phase(48'd0, 32'($urandom_range(1, 10)), 48'd2, 200);
        run_phase(48'd20, 32'hFFFF_FFFF, 48'd4, 200);
    endtask

    initial
    begin : result_sink
        int         stretch;
        sink_mode_t mode;
        stretch = 0;
        mode    = SINK_OPEN;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (long_hold) @(posedge clk);
                long_hold = 0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode    = sink_mode_t'($urandom_range(0, 3));
                    stretch = $urandom_range(5, 60);
                end
                stretch--;
                case (mode)
                    SINK_OPEN:   out_ch.ready <= 1'b1;
                    SINK_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:     out_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin : result_check
        diag_t got;
        diag_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got = '{out_ch.connected, out_ch.min_interval, out_ch.max_interval,
                        out_ch.rate_q8, out_ch.window_closed};
                if (expected_diag_q.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none got %0h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_diag_q.pop_front();
                    check_field("connected", 64'(want.conn), 64'(got.conn));
                    check_field("min_interval", 64'(want.min_iv), 64'(got.min_iv));
                    check_field("max_interval", 64'(want.max_iv), 64'(got.max_iv));
                    check_field("rate_q8", 64'(want.rate), 64'(got.rate));
                    check_field("window_closed", 64'(want.closed), 64'(got.closed));
                    results_checked++;
                end
            end
        end
    end

    initial
    begin
        #15_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.opcode   <= OPC_EVENT;
        in_ch.now_time <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_window_edges();
        test_special_registers();
        test_output_hold_off();
        test_random_traffic();

        settle();
        $display("run covered %0d items and %0d results, %0d windows latched with events",
                 items_sent, results_checked, busy_windows);
        $display("over %0d register settings incl. zero window, zero and saturating rate",
                 settings_used);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: event_rate_monitor.f
rtl/core/erm_pkg.sv
rtl/core/erm_in_if.sv
rtl/core/erm_out_if.sv
rtl/core/erm_cfg.sv
rtl/core/erm_dp.sv
rtl/core/erm_ctrl.sv
rtl/core/event_rate_monitor.sv
tb/sv/testbench.sv
